[sv/pra_pkg.sv]
package pra_pkg;

  // Input opcodes.
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Result kinds as they appear on the result channel.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  // What closes a packet, as recorded in a queue entry.
  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_ACK  = 2'd1,
    END_DONE = 2'd2
  } end_t;

  // Header and acknowledge constants.
  localparam logic [1:0] CONT_CODE   = 2'b01;
  localparam logic [7:0] ACK_BYTE0   = 8'h01;
  localparam logic [7:0] ACK_BYTE1   = 8'h05;
  localparam logic [2:0] START_FIRST = 3'd5;
  localparam logic [2:0] START_NEXT  = 3'd3;
  localparam logic [5:0] TAKEN_MAX   = 6'd63;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One classified input beat: an optional payload byte and an optional packet end.
  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload;
    end_t       end_kind;
    logic [7:0] seq;
    logic       shrt;
  } entry_t;

endpackage

[sv/pra_front.sv]
module pra_front #(
  parameter int PACKET_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic            full,
  input  logic            opcode,
  input  logic [7:0]      data_byte,
  input  logic            packet_end,
  output logic            q_push,
  output pra_pkg::entry_t q_entry
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(PACKET_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       pc_r, pc_nxt;
  logic [2:0]       start_r, start_nxt;
  logic             final_r, final_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [5:0]       bt_r, bt_nxt;
  logic             ta_r, ta_nxt;

  logic       accept;
  logic       is_hdr;
  logic [5:0] hlen;
  logic       hdr_final;
  logic [2:0] hdr_sub;
  logic       hdr_ta;
  logic [5:0] hdr_cnt;
  logic       ta_eff;
  logic [5:0] pc_eff;
  logic       fin_eff;
  logic       ta_end;
  logic       fin_end;
  logic       take;
  logic [5:0] bt_inc;
  logic       shrt;

  // Header decode: a length below the deduction means take-all with a count of zero.
  always_comb begin
    accept    = push && !full;
    is_hdr    = (pos_r == POS_W'(1));
    hlen      = data_byte[7:2];
    hdr_final = (data_byte[1:0] != pra_pkg::CONT_CODE);
    hdr_sub   = 3'd1 + (first_r ? 3'd2 : 3'd0) + (hdr_final ? 3'd1 : 3'd0);
    hdr_ta    = (hlen < 6'(hdr_sub));
    hdr_cnt   = hlen - 6'(hdr_sub);
    ta_eff    = is_hdr ? hdr_ta : ta_r;
    pc_eff    = is_hdr ? (hdr_ta ? 6'd0 : hdr_cnt) : pc_r;
    fin_eff   = is_hdr ? hdr_final : final_r;
    // A packet that ends before its header counts as a final one with no count.
    ta_end    = (pos_r == '0) ? 1'b1 : ta_eff;
    fin_end   = (pos_r == '0) ? 1'b1 : fin_eff;
  end

  // Payload selection and the short flag.
  always_comb begin
    take   = (pos_r >= POS_W'(2)) && (pos_r >= POS_W'(start_r)) && (ta_r || (bt_r < pc_r));
    bt_inc = (take && (bt_r != pra_pkg::TAKEN_MAX)) ? bt_r + 6'd1 : bt_r;
    shrt   = ta_end || (bt_inc < pc_eff);
  end

  // Entry for the queue.
  always_comb begin
    q_push              = accept && (opcode == pra_pkg::OP_BYTE) && (take || packet_end);
    q_entry.has_payload = take;
    q_entry.payload     = data_byte;
    q_entry.seq         = seq_r;
    q_entry.shrt        = packet_end && shrt;
    if (!packet_end) begin
      q_entry.end_kind = pra_pkg::END_NONE;
    end else if (fin_end) begin
      q_entry.end_kind = pra_pkg::END_DONE;
    end else begin
      q_entry.end_kind = pra_pkg::END_ACK;
    end
  end

  // Packet state update.
  always_comb begin
    pos_nxt   = pos_r;
    pc_nxt    = pc_r;
    start_nxt = start_r;
    final_nxt = final_r;
    first_nxt = first_r;
    seq_nxt   = seq_r;
    bt_nxt    = bt_r;
    ta_nxt    = ta_r;
    if (accept) begin
      if (opcode == pra_pkg::OP_BEGIN) begin
        pos_nxt   = '0;
        pc_nxt    = '0;
        start_nxt = pra_pkg::START_NEXT;
        final_nxt = 1'b0;
        bt_nxt    = '0;
        ta_nxt    = 1'b0;
        first_nxt = 1'b1;
        seq_nxt   = '0;
      end else begin
        if (is_hdr) begin
          pc_nxt    = pc_eff;
          ta_nxt    = hdr_ta;
          final_nxt = hdr_final;
          start_nxt = first_r ? pra_pkg::START_FIRST : pra_pkg::START_NEXT;
        end
        bt_nxt = bt_inc;
        if (!packet_end) begin
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end else begin
          pos_nxt   = '0;
          pc_nxt    = '0;
          start_nxt = pra_pkg::START_NEXT;
          final_nxt = 1'b0;
          bt_nxt    = '0;
          ta_nxt    = 1'b0;
          first_nxt = 1'b0;
          if (!fin_end) begin
            seq_nxt = seq_r + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      pc_r    <= '0;
      start_r <= pra_pkg::START_NEXT;
      final_r <= 1'b0;
      first_r <= 1'b1;
      seq_r   <= '0;
      bt_r    <= '0;
      ta_r    <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      pc_r    <= pc_nxt;
      start_r <= start_nxt;
      final_r <= final_nxt;
      first_r <= first_nxt;
      seq_r   <= seq_nxt;
      bt_r    <= bt_nxt;
      ta_r    <= ta_nxt;
    end
  end

endmodule

[sv/pra_queue.sv]
module pra_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  pra_pkg::entry_t wr_entry,
  input  logic            rd_en,
  output pra_pkg::entry_t rd_entry,
  output logic            q_full,
  output logic            q_empty
);

  localparam int CNT_W = pra_pkg::QPTR_W + 1;

  pra_pkg::entry_t               mem_r [pra_pkg::QDEPTH];
  logic [pra_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pra_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  // Flags and pointer updates.
  always_comb begin
    q_full     = (cnt_r == CNT_W'(pra_pkg::QDEPTH));
    q_empty    = (cnt_r == '0);
    wr_ptr_nxt = wr_ptr_r + (wr_en ? pra_pkg::QPTR_W'(1) : '0);
    rd_ptr_nxt = rd_ptr_r + (rd_en ? pra_pkg::QPTR_W'(1) : '0);
    cnt_nxt    = cnt_r + (wr_en ? CNT_W'(1) : '0) - (rd_en ? CNT_W'(1) : '0);
    rd_entry   = mem_r[rd_ptr_r];
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/pra_back.sv]
module pra_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pra_pkg::entry_t head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic            short_packet,
  output logic            run_last
);

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] nres;
  logic [1:0] j;
  logic       take_beat;
  pra_pkg::kind_t k;

  // Expand the head entry into its result beats.
  always_comb begin
    nres = (head.has_payload ? 3'd1 : 3'd0) +
           ((head.end_kind == pra_pkg::END_DONE) ? 3'd1 :
            (head.end_kind == pra_pkg::END_ACK)  ? 3'd3 : 3'd0);
    j        = idx_r - (head.has_payload ? 2'd1 : 2'd0);
    run_last = (3'(idx_r) == nres - 3'd1);
    short_packet = head.shrt;
    if (head.has_payload && (idx_r == 2'd0)) begin
      k        = pra_pkg::KIND_PAYLOAD;
      out_byte = head.payload;
    end else if (head.end_kind == pra_pkg::END_DONE) begin
      k        = pra_pkg::KIND_DONE;
      out_byte = 8'd0;
    end else begin
      k = pra_pkg::KIND_ACK;
      case (j)
        2'd0:    out_byte = pra_pkg::ACK_BYTE0;
        2'd1:    out_byte = pra_pkg::ACK_BYTE1;
        default: out_byte = head.seq;
      endcase
    end
    kind = k;
  end

  // Beat handshake and beat index within the entry.
  always_comb begin
    empty     = q_empty;
    take_beat = pop && !q_empty;
    q_pop     = take_beat && run_last;
    idx_nxt   = idx_r;
    if (take_beat) begin
      idx_nxt = run_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[sv/packet_reassembler_with_ack_top.sv]
// Packet reassembler with acknowledge generation.
// Input channel: one beat per received packet byte (opcode 1) or a begin marker
// (opcode 0), accepted when push is high and full is low.
// Result channel: payload bytes, three-byte acknowledge bursts and done markers,
// shown while empty is low and taken when pop is high.
// The front classifies each input beat in the cycle it is accepted and writes at
// most one queue entry; the result ports show the registered queue head.
// The front accepts one beat per cycle while full is low; the back delivers one
// result beat per cycle while pop is high, so a packet end with an acknowledge
// gives three beats (four with a payload byte) that the four-entry queue absorbs.
// full rises only when that queue is full, which is what throttles the input.
// Reset clears the packet state, marks the next packet as first, restarts the
// acknowledge sequence at zero and empties the queue.
// When the receiver stalls, the current result holds and the input keeps being
// accepted until the queue fills.
module packet_reassembler_with_ack_top #(
  parameter int PACKET_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic       in_packet_end,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_short_packet,
  output logic       out_run_last
);

  pra_pkg::entry_t wr_entry;
  pra_pkg::entry_t head;
  logic            wr_en;
  logic            rd_en;
  logic            q_full;
  logic            q_empty;

  assign full = q_full;

  pra_front #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .opcode     (in_opcode),
    .data_byte  (in_data_byte),
    .packet_end (in_packet_end),
    .q_push     (wr_en),
    .q_entry    (wr_entry)
  );

  pra_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (head),
    .q_full   (q_full),
    .q_empty  (q_empty)
  );

  pra_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (rd_en),
    .empty        (empty),
    .pop          (pop),
    .kind         (out_kind),
    .out_byte     (out_out_byte),
    .short_packet (out_short_packet),
    .run_last     (out_run_last)
  );

endmodule

[sv/pra_checker.sv]
module pra_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_kind,
  input logic [7:0] out_out_byte,
  input logic       out_short_packet,
  input logic       out_run_last
);

  // A done result carries no byte and closes its input's results.
  a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == pra_pkg::KIND_DONE)) |-> (out_out_byte == 8'd0) && out_run_last)
    else $error("done result malformed");

  // A payload byte that closes its input's results did not end a packet, so it is never short.
  a_payload_short: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == pra_pkg::KIND_PAYLOAD) && out_run_last) |-> !out_short_packet)
    else $error("short flag on a payload beat that did not end its packet");

  // The first acknowledge byte is followed at once by the second.
  a_ack_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && (out_kind == pra_pkg::KIND_ACK) && (out_out_byte == pra_pkg::ACK_BYTE0)
     && !out_run_last)
    |=> !empty && (out_kind == pra_pkg::KIND_ACK) && (out_out_byte == pra_pkg::ACK_BYTE1))
    else $error("acknowledge burst broken");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_kind) && $stable(out_out_byte)
                         && $stable(out_run_last))
    else $error("stalled result changed");

endmodule

bind packet_reassembler_with_ack_top pra_checker u_pra_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .empty            (empty),
  .pop              (pop),
  .out_kind         (out_kind),
  .out_out_byte     (out_out_byte),
  .out_short_packet (out_short_packet),
  .out_run_last     (out_run_last)
);

[tb/packet_reassembler_with_ack_top_tb.sv]
`timescale 1ns / 100ps

module packet_reassembler_with_ack_top_tb;

  localparam int PKT_BYTES  = 64;
  localparam int MAX_PRINTS = 40;

  // One result beat as the receiver should see it.
  typedef struct {
    pra_pkg::kind_t kind;
    logic [7:0]     data;
    logic           shrt;
    logic           last;
  } result_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic       in_opcode;
  logic [7:0] in_data_byte;
  logic       in_packet_end;
  logic       empty;
  logic       pop;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_short_packet;
  logic       out_run_last;

  // Reassembly state as the block should hold it.
  logic [5:0] byte_pos;
  logic [5:0] pay_count;
  logic [2:0] pay_start;
  logic       final_pkt;
  logic       first_pkt;
  logic [7:0] ack_seq;
  logic [5:0] taken;
  logic       take_all;

  result_t awaited_results[$];
  int      beats_sent;
  int      mismatches;
  int      hold_cycles;
  bit      src_idle;
  bit      sink_idle;

  packet_reassembler_with_ack_top #(
    .PACKET_BYTES(PKT_BYTES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .in_packet_end   (in_packet_end),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_short_packet(out_short_packet),
    .out_run_last    (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net in case the block stops moving.
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_packet();
    byte_pos  = '0;
    pay_count = '0;
    pay_start = pra_pkg::START_NEXT;
    final_pkt = 1'b0;
    taken     = '0;
    take_all  = 1'b0;
  endfunction

  // Works out the result beats caused by one accepted input beat.
  task automatic predict_reassembly(input logic op, input logic [7:0] b, input logic e);
    int      cnt;
    logic    shrt;
    result_t burst[$];
    if (op == pra_pkg::OP_BEGIN) begin
      clear_packet();
      first_pkt = 1'b1;
      ack_seq   = '0;
      return;
    end
    // The header byte fixes where the payload starts and how long it runs.
    if (byte_pos == 6'd1) begin
      cnt       = int'(b[7:2]) - 1;
      final_pkt = (b[1:0] != pra_pkg::CONT_CODE);
      if (first_pkt) begin
        cnt -= 2;
        pay_start = pra_pkg::START_FIRST;
      end else begin
        pay_start = pra_pkg::START_NEXT;
      end
      if (final_pkt) cnt -= 1;
      if (cnt < 0) begin
        take_all  = 1'b1;
        pay_count = '0;
      end else begin
        take_all  = 1'b0;
        pay_count = cnt[5:0];
      end
    end
    if (byte_pos >= 6'd2 && byte_pos >= pay_start && (take_all || taken < pay_count)) begin
      burst.push_back(result_t'{pra_pkg::KIND_PAYLOAD, b, 1'b0, 1'b0});
      if (taken < pra_pkg::TAKEN_MAX) taken++;
    end
    if (!e) begin
      if (byte_pos < PKT_BYTES - 1) byte_pos++;
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    end else begin
      // A packet that ends before its header counts as a final one with no length.
      if (byte_pos == 6'd0) begin
        final_pkt = 1'b1;
        take_all  = 1'b1;
      end
      shrt = take_all || (taken < pay_count);
      if (burst.size() > 0) burst[0].shrt = shrt;
      if (final_pkt) begin
        burst.push_back(result_t'{pra_pkg::KIND_DONE, 8'h00, shrt, 1'b1});
      end else begin
        burst.push_back(result_t'{pra_pkg::KIND_ACK, pra_pkg::ACK_BYTE0, shrt, 1'b0});
        burst.push_back(result_t'{pra_pkg::KIND_ACK, pra_pkg::ACK_BYTE1, shrt, 1'b0});
        burst.push_back(result_t'{pra_pkg::KIND_ACK, ack_seq, shrt, 1'b1});
        ack_seq++;
      end
      clear_packet();
      first_pkt = 1'b0;
    end
    foreach (burst[i]) awaited_results.push_back(burst[i]);
  endtask

  // Offers one beat (after a random gap if src_idle) and holds it until it is taken.
  task automatic send_beat(input logic op, input logic [7:0] b, input logic e);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) @(negedge clk) push <= 1'b0;
    @(negedge clk);
    push          <= 1'b1;
    in_opcode     <= op;
    in_data_byte  <= b;
    in_packet_end <= e;
    do @(posedge clk); while (full);
    predict_reassembly(op, b, e);
    beats_sent++;
  endtask

  // Sends one packet; byte 1 carries the header, the last byte closes the packet.
  task automatic send_packet(input int nbytes, input logic [7:0] hdr, input bit may_abort);
    for (int i = 0; i < nbytes; i++) begin
      if (may_abort && $urandom_range(0, 59) == 0) begin
        send_beat(pra_pkg::OP_BEGIN, 8'($urandom_range(0, 255)), 1'b0);
        return;
      end
      send_beat(pra_pkg::OP_BYTE, (i == 1) ? hdr : 8'($urandom_range(0, 255)),
                i == nbytes - 1);
    end
  endtask

  // Compares one accepted result beat with the oldest one awaited.
  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h", out_kind, out_out_byte));
      return;
    end
    want = awaited_results.pop_front();
    if (out_kind !== want.kind)
      report_mismatch($sformatf("kind %0d, wanted %0d", out_kind, want.kind));
    if (out_out_byte !== want.data)
      report_mismatch($sformatf("byte %02h, wanted %02h", out_out_byte, want.data));
    if (out_short_packet !== want.shrt)
      report_mismatch($sformatf("short flag %b, wanted %b", out_short_packet, want.shrt));
    if (out_run_last !== want.last)
      report_mismatch($sformatf("last flag %b, wanted %b", out_run_last, want.last));
  endtask

  // Result side: random stalls, an occasional long hold, and a check on each beat.
  initial begin : result_sink
    int stall;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        repeat (hold_cycles) @(negedge clk) pop <= 1'b0;
        hold_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 3) : 0;
      repeat (stall) @(negedge clk) pop <= 1'b0;
      @(negedge clk) pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result();
    end
  end

  // Edge cases of packet framing, header decoding and begin handling.
  task automatic directed_test();
    // A packet that ends on its very first byte.
    send_beat(pra_pkg::OP_BYTE, 8'hff, 1'b1);
    // Begin restarts the transfer and yields nothing.
    send_beat(pra_pkg::OP_BEGIN, 8'ha5, 1'b0);
    // First continuing packet: payload from offset 5, one byte long.
    send_beat(pra_pkg::OP_BYTE, 8'h00, 1'b0);
    send_beat(pra_pkg::OP_BYTE, {6'd4, pra_pkg::CONT_CODE}, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h12, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h34, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h56, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'hff, 1'b1);
    // Final packet with the longest header, cut short.
    send_beat(pra_pkg::OP_BYTE, 8'h7f, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'hff, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h80, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h00, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h7f, 1'b1);
    // Zero length on a continuing packet: everything from offset 3 is taken.
    send_beat(pra_pkg::OP_BYTE, 8'h55, 1'b0);
    send_beat(pra_pkg::OP_BYTE, {6'd0, pra_pkg::CONT_CODE}, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h00, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'haa, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h33, 1'b1);
    // Packet that ends on its header byte.
    send_beat(pra_pkg::OP_BYTE, 8'h00, 1'b0);
    send_beat(pra_pkg::OP_BYTE, {6'd3, 2'b00}, 1'b1);
    // Begin arriving part way through a packet drops it.
    send_beat(pra_pkg::OP_BYTE, 8'h11, 1'b0);
    send_beat(pra_pkg::OP_BYTE, {6'd8, pra_pkg::CONT_CODE}, 1'b0);
    send_beat(pra_pkg::OP_BYTE, 8'h22, 1'b0);
    send_beat(pra_pkg::OP_BEGIN, 8'h5a, 1'b1);
  endtask

  // An overlong take-all packet sent flat out while the receiver holds off.
  task automatic overlong_pressure_test();
    send_beat(pra_pkg::OP_BEGIN, 8'h3c, 1'b0);
    src_idle    = 1'b0;
    hold_cycles = 40;
    send_packet(70, {6'd0, pra_pkg::CONT_CODE}, 1'b0);
    src_idle = 1'b1;
  endtask

  // A run of short continuing packets that step the acknowledge sequence.
  task automatic ack_wrap_test();
    send_beat(pra_pkg::OP_BEGIN, 8'h00, 1'b0);
    for (int i = 0; i < 50; i++) begin
      if (i == 25) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      send_packet(2, {6'($urandom_range(0, 63)), pra_pkg::CONT_CODE}, 1'b0);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Mostly well-formed packets of random size and content, with stray begins.
  task automatic random_test();
    int         first_beat;
    int         nbytes;
    int         len;
    logic [1:0] code;
    first_beat = beats_sent;
    while (beats_sent - first_beat < 120) begin
      if ($urandom_range(0, 7) == 0) src_idle = ~src_idle;
      if ($urandom_range(0, 7) == 0) sink_idle = ~sink_idle;
      if ($urandom_range(0, 11) == 0) begin
        send_beat(pra_pkg::OP_BEGIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        continue;
      end
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) begin
        do code = 2'($urandom_range(0, 3)); while (code == pra_pkg::CONT_CODE);
      end else begin
        code = pra_pkg::CONT_CODE;
      end
      case ($urandom_range(0, 7))
        0: nbytes = $urandom_range(1, 70);
        1: nbytes = $urandom_range(1, 3);
        default: nbytes = len + $urandom_range(1, 4);
      endcase
      send_packet(nbytes, {len[5:0], code}, 1'b1);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin : run
    int waited;
    rst_n         = 1'b0;
    push          = 1'b0;
    in_opcode     = pra_pkg::OP_BEGIN;
    in_data_byte  = 8'h00;
    in_packet_end = 1'b0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    hold_cycles   = 0;
    beats_sent    = 0;
    mismatches    = 0;
    clear_packet();
    first_pkt = 1'b1;
    ack_seq   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    directed_test();
    overlong_pressure_test();
    ack_wrap_test();
    random_test();
    @(negedge clk) push <= 1'b0;

    // Drain, then keep watching for anything unexpected before the verdict.
    waited = 0;
    while (awaited_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
